/* design/bse_pkg.sv */
// ----------------------------------------------------------------------------
// bse_pkg - shared types and constants for the bayer superpixel extract unit
// Holds the request and response word layouts, register indexes and the
// bayer layout codes.
// ----------------------------------------------------------------------------
package bse_pkg;

   // width of every word field and of the line width register
   localparam int FIELD_BITS      = 16;
   localparam int LINE_WIDTH_BITS = 14;
   localparam int CSR_INDEX_BITS  = 2;

   // byte mode clamp level
   localparam logic [FIELD_BITS-1:0] BYTE_MAX = 16'd255;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BAYER_LAYOUT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BYTE_MODE    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_WIDTH   = 2'd2;

   // color filter arrangement of the top-left quad position
   typedef enum logic [1:0] {
      LAYOUT_RGGB = 2'd0,
      LAYOUT_BGGR = 2'd1,
      LAYOUT_GRBG = 2'd2,
      LAYOUT_GBRG = 2'd3
   } layout_type;

   // input word
   typedef struct packed {
      logic [FIELD_BITS-1:0] pixel;
      logic                  frame_start;
   } req_word_type;

   // result word
   typedef struct packed {
      logic [FIELD_BITS-1:0] plane0;
      logic [FIELD_BITS-1:0] plane1;
      logic [FIELD_BITS-1:0] plane2;
      logic [FIELD_BITS-1:0] plane3;
      logic [FIELD_BITS-1:0] ha_value;
      logic [FIELD_BITS-1:0] oiii_value;
      logic [FIELD_BITS-1:0] green_value;
   } rsp_word_type;

endpackage

/* design/bse_ram.sv */
// ----------------------------------------------------------------------------
// bse_ram - generic simple dual port ram
// One write port and one read port, read data registered with a read enable
// so that it holds while no read is issued.
// ----------------------------------------------------------------------------
module bse_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/bayer_superpixel_extract_unit.sv */
// ----------------------------------------------------------------------------
// bayer_superpixel_extract_unit - raw bayer stream to superpixel results
// Keeps the even row of a raw bayer stream in a line memory and emits one
// superpixel word for every odd-row, odd-column pixel.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one raw pixel word per handshake in raster order;
//   frame_start on the first pixel of a frame puts it at row 0, column 0.
//   rsp channel: one word per closed 2x2 quad, carrying the four split
//   planes, the ha pixel, the oiii mean of the other three and the green
//   mean. Pixels that close no quad give no word; a trailing odd column or
//   odd row is dropped.
//   csr channel: register writes (0 bayer_layout, 1 byte_mode, 2 line_width),
//   always ready; write them only while no pixel is in flight.
// Throughput: one pixel per cycle unless a result stall holds the input;
//   one line memory access per pixel (even rows write, odd rows read) sets it.
// Pipeline: the pixel closing a quad passes memory read, quad assembly, then
//   mean and clamp into the output register.
// Reset: position goes to row 0, column 0, registers to RGGB, 16-bit mode,
//   width 2. The line memory is not cleared; it is always written before
//   it is read.
// Stall: with rsp_ready low the result holds in the output register while
//   the two stages behind it keep filling; req_ready drops only once the
//   output register and the quad stage are full and the read stage holds a
//   quad-closing pixel.
// ----------------------------------------------------------------------------
module bayer_superpixel_extract_unit #(
   parameter int MAX_WIDTH  = 8192,
   parameter int PIXEL_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // pixel input
   input  logic                               req_valid,
   output logic                               req_ready,
   input  bse_pkg::req_word_type              req_word,
   // result output
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output bse_pkg::rsp_word_type              rsp_word,
   // register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bse_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bse_pkg::LINE_WIDTH_BITS-1:0] csr_data
);

   import bse_pkg::*;

   localparam int CW      = $clog2(MAX_WIDTH);
   localparam int WW      = (CW + 1 > LINE_WIDTH_BITS) ? CW + 1 : LINE_WIDTH_BITS;
   localparam int PB      = PIXEL_BITS;
   localparam int SH      = PIXEL_BITS + 3;
   localparam int PW      = 2 * PIXEL_BITS + 4;
   localparam logic [PB+1:0] RECIP = (PB+2)'((1 << SH) / 3 + 1);

   // configuration registers
   layout_type                 layout_ff, layout_in;
   logic                       byte_mode_ff, byte_mode_in;
   logic [LINE_WIDTH_BITS-1:0] line_width_ff, line_width_in;

   // raster position
   logic [CW-1:0] col_ff, col_in;
   logic          row_odd_ff, row_odd_in;

   // stage 1: memory read in flight
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_emit_ff, s1_emit_in;
   logic          s1_hold_ff, s1_hold_in;
   logic [PB-1:0] s1_px_ff, s1_px_in;

   // left column of the quad being built
   logic [PB-1:0] tl_ff, tl_in;
   logic [PB-1:0] held_ff, held_in;

   // stage 2: assembled quad
   logic          s2_valid_ff, s2_valid_in;
   logic [PB-1:0] s2_tl_ff, s2_tl_in;
   logic [PB-1:0] s2_tr_ff, s2_tr_in;
   logic [PB-1:0] s2_bl_ff, s2_bl_in;
   logic [PB-1:0] s2_br_ff, s2_br_in;
   logic [PB-1:0] s2_ha_ff, s2_ha_in;
   logic [PB+1:0] s2_rest_ff, s2_rest_in;
   logic [PB-1:0] s2_green_ff, s2_green_in;

   // stage 3: output register
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  out_ff, out_in;

   // memory port
   logic          ram_wr_en, ram_rd_en;
   logic [CW-1:0] ram_addr;
   logic [PB-1:0] ram_rd_data;

   logic          accept;
   logic          en1, en2, en3, s1_go;
   logic [WW-1:0] lw_ext, w_eff, col_next_ext;
   logic [CW-1:0] col_cur;
   logic          row_cur;
   logic [PB-1:0] px;
   logic [PB-1:0] tr_cur;
   logic [PW-1:0] prod;

   // stage enables, each stage moves when the one ahead frees up
   assign en3   = !rsp_valid_ff || rsp_ready;
   assign en2   = !s2_valid_ff || en3;
   assign s1_go = s1_valid_ff && (s1_hold_ff || en2);
   assign en1   = !s1_valid_ff || s1_go;

   assign req_ready = en1;
   assign accept    = req_valid && en1;
   assign csr_ready = 1'b1;
   assign px        = req_word.pixel[PB-1:0];

   // register writes
   always_comb begin
      layout_in     = layout_ff;
      byte_mode_in  = byte_mode_ff;
      line_width_in = line_width_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BAYER_LAYOUT: layout_in     = layout_type'(csr_data[1:0]);
            CSR_BYTE_MODE:    byte_mode_in  = csr_data[0];
            CSR_LINE_WIDTH:   line_width_in = csr_data;
            default: ;
         endcase
      end
   end

   // effective width and position of the incoming pixel
   always_comb begin
      lw_ext = WW'(line_width_ff);
      w_eff  = lw_ext;
      if (lw_ext < WW'(2)) begin
         w_eff = WW'(2);
      end else if (lw_ext > WW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end
      col_cur = col_ff;
      row_cur = row_odd_ff;
      if (req_word.frame_start) begin
         col_cur = '0;
         row_cur = 1'b0;
      end
      if (WW'(col_cur) >= w_eff) begin
         col_cur = '0;
         row_cur = !row_cur;
      end
      col_next_ext = WW'(col_cur) + WW'(1);
   end

   // next position
   always_comb begin
      col_in     = col_ff;
      row_odd_in = row_odd_ff;
      if (accept) begin
         if (col_next_ext >= w_eff) begin
            col_in     = '0;
            row_odd_in = !row_cur;
         end else begin
            col_in     = col_next_ext[CW-1:0];
            row_odd_in = row_cur;
         end
      end
   end

   // line memory: write in even rows, read in odd rows
   assign ram_wr_en = accept && !row_cur;
   assign ram_rd_en = accept && row_cur;
   assign ram_addr  = col_cur;

   bse_ram #(
      .WIDTH (PB),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_addr),
      .wr_data (px),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_addr),
      .rd_data (ram_rd_data)
   );

   // stage 1 load, only odd-row pixels go on
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_emit_in  = s1_emit_ff;
      s1_hold_in  = s1_hold_ff;
      s1_px_in    = s1_px_ff;
      if (en1) begin
         s1_valid_in = accept && row_cur;
         s1_emit_in  = col_cur[0];
         s1_hold_in  = !col_cur[0];
         s1_px_in    = px;
      end
   end

   // left column capture on even-column odd-row pixels
   always_comb begin
      tl_in   = tl_ff;
      held_in = held_ff;
      if (s1_go && s1_hold_ff) begin
         tl_in   = ram_rd_data;
         held_in = s1_px_ff;
      end
   end

   // quad assembly with ha pick and sums by layout
   assign tr_cur = ram_rd_data;

   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_tl_in    = s2_tl_ff;
      s2_tr_in    = s2_tr_ff;
      s2_bl_in    = s2_bl_ff;
      s2_br_in    = s2_br_ff;
      s2_ha_in    = s2_ha_ff;
      s2_rest_in  = s2_rest_ff;
      s2_green_in = s2_green_ff;
      if (en2) begin
         s2_valid_in = s1_valid_ff && s1_emit_ff;
         s2_tl_in    = tl_ff;
         s2_tr_in    = tr_cur;
         s2_bl_in    = held_ff;
         s2_br_in    = s1_px_ff;
         unique case (layout_ff)
            LAYOUT_RGGB: begin
               s2_ha_in   = tl_ff;
               s2_rest_in = (PB+2)'(tr_cur) + (PB+2)'(held_ff) + (PB+2)'(s1_px_ff);
            end
            LAYOUT_BGGR: begin
               s2_ha_in   = s1_px_ff;
               s2_rest_in = (PB+2)'(tl_ff) + (PB+2)'(tr_cur) + (PB+2)'(held_ff);
            end
            LAYOUT_GRBG: begin
               s2_ha_in   = tr_cur;
               s2_rest_in = (PB+2)'(tl_ff) + (PB+2)'(held_ff) + (PB+2)'(s1_px_ff);
            end
            default: begin
               s2_ha_in   = held_ff;
               s2_rest_in = (PB+2)'(tl_ff) + (PB+2)'(tr_cur) + (PB+2)'(s1_px_ff);
            end
         endcase
         case (layout_ff) inside
            LAYOUT_RGGB, LAYOUT_BGGR: begin
               s2_green_in = PB'(((PB+1)'(tr_cur) + (PB+1)'(held_ff)) >> 1);
            end
            default: begin
               s2_green_in = PB'(((PB+1)'(tl_ff) + (PB+1)'(s1_px_ff)) >> 1);
            end
         endcase
      end
   end

   // mean of three by reciprocal multiply
   assign prod = PW'(s2_rest_ff) * PW'(RECIP);

   // output register with byte clamp
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_in       = out_ff;
      if (en3) begin
         rsp_valid_in       = s2_valid_ff;
         out_in.plane0      = (byte_mode_ff && FIELD_BITS'(s2_bl_ff) > BYTE_MAX) ?
                              BYTE_MAX : FIELD_BITS'(s2_bl_ff);
         out_in.plane1      = (byte_mode_ff && FIELD_BITS'(s2_tl_ff) > BYTE_MAX) ?
                              BYTE_MAX : FIELD_BITS'(s2_tl_ff);
         out_in.plane2      = (byte_mode_ff && FIELD_BITS'(s2_br_ff) > BYTE_MAX) ?
                              BYTE_MAX : FIELD_BITS'(s2_br_ff);
         out_in.plane3      = (byte_mode_ff && FIELD_BITS'(s2_tr_ff) > BYTE_MAX) ?
                              BYTE_MAX : FIELD_BITS'(s2_tr_ff);
         out_in.ha_value    = (byte_mode_ff && FIELD_BITS'(s2_ha_ff) > BYTE_MAX) ?
                              BYTE_MAX : FIELD_BITS'(s2_ha_ff);
         out_in.oiii_value  = FIELD_BITS'(prod[SH +: PB]);
         out_in.green_value = FIELD_BITS'(s2_green_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = out_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff     <= LAYOUT_RGGB;
         byte_mode_ff  <= 1'b0;
         line_width_ff <= LINE_WIDTH_BITS'(2);
         col_ff        <= '0;
         row_odd_ff    <= 1'b0;
         held_ff       <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         layout_ff     <= layout_in;
         byte_mode_ff  <= byte_mode_in;
         line_width_ff <= line_width_in;
         col_ff        <= col_in;
         row_odd_ff    <= row_odd_in;
         held_ff       <= held_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_emit_ff  <= s1_emit_in;
      s1_hold_ff  <= s1_hold_in;
      s1_px_ff    <= s1_px_in;
      tl_ff       <= tl_in;
      s2_tl_ff    <= s2_tl_in;
      s2_tr_ff    <= s2_tr_in;
      s2_bl_ff    <= s2_bl_in;
      s2_br_ff    <= s2_br_in;
      s2_ha_ff    <= s2_ha_in;
      s2_rest_ff  <= s2_rest_in;
      s2_green_ff <= s2_green_in;
      out_ff      <= out_in;
   end

`ifndef SYNTHESIS
   // the line memory is never written and read in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("line memory write and read collide");

   // input stalls only when all three stages are occupied
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s2_valid_ff && rsp_valid_ff))
      else $error("input stalled with a free stage");

   // a frame start pixel leaves the position at column 1 of the even row
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_word.frame_start) |=> (col_ff == CW'(1) && !row_odd_ff))
      else $error("frame start did not restart the raster position");

   // a held stage 1 entry is either a quad closer or a left capture
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (s1_emit_ff != s1_hold_ff))
      else $error("stage 1 entry kind is inconsistent");

   // a result enters the output stage only from a filled quad stage
   assert property (@(posedge clock) disable iff (reset)
      (en3 && !s2_valid_ff) |=> !rsp_valid_ff)
      else $error("result produced without an assembled quad");
`endif

endmodule

/* tb/sv/bayer_superpixel_checker.sv */
// ----------------------------------------------------------------------------
// bayer_superpixel_checker - superpixel predictor and result comparison
// Watches the pixel, result and register channels of the extract unit. It
// keeps its own line store, raster position and register copies, works out
// the superpixel word that each accepted pixel closes, and compares every
// accepted result word field by field with the oldest predicted word.
// ----------------------------------------------------------------------------
module bayer_superpixel_checker #(
   parameter int MAX_WIDTH = 8192
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  bse_pkg::req_word_type               req_word,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  bse_pkg::rsp_word_type               rsp_word,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [bse_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [bse_pkg::LINE_WIDTH_BITS-1:0] csr_data,
   output int                                  mismatch_count,
   output int                                  pending_count
);

   import bse_pkg::*;

   localparam int STORE_BITS = $clog2(MAX_WIDTH);

   // register copies
   layout_type                 layout_reg;
   logic                       byte_reg;
   logic [LINE_WIDTH_BITS-1:0] width_reg;

   // raster position and pixel history
   logic [FIELD_BITS-1:0] line_store [MAX_WIDTH];
   int unsigned           col_pos;
   logic                  odd_row;
   logic [FIELD_BITS-1:0] left_pixel;

   // superpixel words still to come out of the block
   rsp_word_type superpixel_q [$];

   // line width as the block uses it
   function automatic int unsigned active_span();
      if (width_reg < 2) return 2;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return 32'(width_reg);
   endfunction

   // 8-bit sources clamp at the byte maximum
   function automatic logic [FIELD_BITS-1:0] byte_clamp(input logic [FIELD_BITS-1:0] value);
      return (byte_reg && value > BYTE_MAX) ? BYTE_MAX : value;
   endfunction

   function automatic int field_mismatch(input string name, input logic [FIELD_BITS-1:0] want,
                                         input logic [FIELD_BITS-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // advance the raster by one pixel and queue the superpixel it closes
   task automatic predict_superpixel(input req_word_type word);
      int unsigned           span;
      int unsigned           col;
      int unsigned           oiii_sum;
      int unsigned           green_sum;
      logic [STORE_BITS-1:0] addr;
      logic [FIELD_BITS-1:0] tl, tr, bl, br, ha;
      rsp_word_type          sp;
      span = active_span();
      if (word.frame_start) begin
         col_pos = 0;
         odd_row = 1'b0;
      end
      // width shrunk under the current position: next row starts here
      if (col_pos >= span) begin
         col_pos = 0;
         odd_row = ~odd_row;
      end
      col  = col_pos;
      addr = STORE_BITS'(col);
      if (!odd_row) begin
         line_store[addr] = word.pixel;
      end else if (col % 2 == 0) begin
         left_pixel = word.pixel;
      end else begin
         tl = line_store[addr - 1'b1];
         tr = line_store[addr];
         bl = left_pixel;
         br = word.pixel;
         case (layout_reg)
            LAYOUT_RGGB: ha = tl;
            LAYOUT_BGGR: ha = br;
            LAYOUT_GRBG: ha = tr;
            default:     ha = bl;
         endcase
         if (layout_reg == LAYOUT_RGGB || layout_reg == LAYOUT_BGGR) begin
            green_sum = (32'(tr) + 32'(bl)) >> 1;
         end else begin
            green_sum = (32'(tl) + 32'(br)) >> 1;
         end
         oiii_sum = (32'(tl) + 32'(tr) + 32'(bl) + 32'(br) - 32'(ha)) / 3;
         sp.plane0      = byte_clamp(bl);
         sp.plane1      = byte_clamp(tl);
         sp.plane2      = byte_clamp(br);
         sp.plane3      = byte_clamp(tr);
         sp.ha_value    = byte_clamp(ha);
         sp.oiii_value  = oiii_sum[FIELD_BITS-1:0];
         sp.green_value = green_sum[FIELD_BITS-1:0];
         superpixel_q.push_back(sp);
      end
      if (col + 1 >= span) begin
         col_pos = 0;
         odd_row = ~odd_row;
      end else begin
         col_pos = col + 1;
      end
   endtask

   // all three channels sampled on the rising edge
   always @(posedge clock) begin
      rsp_word_type want;
      int           fails;
      fails = mismatch_count;
      if (reset) begin
         layout_reg = LAYOUT_RGGB;
         byte_reg   = 1'b0;
         width_reg  = LINE_WIDTH_BITS'(2);
         col_pos    = 0;
         odd_row    = 1'b0;
         left_pixel = '0;
         superpixel_q.delete();
         fails = 0;
      end else begin
         // result word against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (superpixel_q.size() == 0) begin
               $error("result word with no superpixel expected");
               fails++;
            end else begin
               want = superpixel_q.pop_front();
               fails += field_mismatch("plane0", want.plane0, rsp_word.plane0);
               fails += field_mismatch("plane1", want.plane1, rsp_word.plane1);
               fails += field_mismatch("plane2", want.plane2, rsp_word.plane2);
               fails += field_mismatch("plane3", want.plane3, rsp_word.plane3);
               fails += field_mismatch("ha_value", want.ha_value, rsp_word.ha_value);
               fails += field_mismatch("oiii_value", want.oiii_value, rsp_word.oiii_value);
               fails += field_mismatch("green_value", want.green_value, rsp_word.green_value);
            end
         end
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BAYER_LAYOUT: layout_reg = layout_type'(csr_data[1:0]);
               CSR_BYTE_MODE:    byte_reg   = csr_data[0];
               CSR_LINE_WIDTH:   width_reg  = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_superpixel(req_word);
      end
      mismatch_count <= fails;
      pending_count  <= superpixel_q.size();
   end

endmodule

/* tb/sv/tb_bayer_superpixel_extract_unit.sv */
// ----------------------------------------------------------------------------
// tb_bayer_superpixel_extract_unit - raw bayer stream testbench
// Drives raster pixel words into the extract unit under a series of register
// settings: a short directed pass over the corners and every bayer layout,
// then random frames with random sizes. Both channels idle at random; a
// checker beside the block predicts and compares every superpixel word.
// ----------------------------------------------------------------------------
module tb_bayer_superpixel_extract_unit;
   import bse_pkg::*;

   localparam int MAX_WIDTH     = 8192;
   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 6;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD     = 300;
   localparam int IDLE_LIMIT    = 4000;
   localparam int RANDOM_PIXELS = 500;
   localparam int STALL_PHASE   = 2;

   // index with no register behind it
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED = 2'd3;

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   req_word_type               req_word  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rsp_word_type               rsp_word;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_BITS-1:0]  csr_index = '0;
   logic [LINE_WIDTH_BITS-1:0] csr_data  = '0;

   int          mismatch_count;
   int          pending_count;
   int          stall_requests = 0;
   int          stall_served   = 0;
   int          hold_left      = 0;
   int          idle_cycles    = 0;
   logic        rsp_burst      = 1'b0;
   bit          req_burst      = 1'b0;
   int unsigned cur_span       = 2;

   always #HALF_PERIOD clock = ~clock;

   bayer_superpixel_extract_unit #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (FIELD_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   bayer_superpixel_checker #(
      .MAX_WIDTH (MAX_WIDTH)
   ) quad_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_word       (req_word),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_word       (rsp_word),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // idle stretch length: mostly short, now and then long
   function automatic int idle_span();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return $urandom_range(1, 3);
      if (pick < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // pixel values weighted toward the byte clamp and the full-scale ends
   function automatic logic [FIELD_BITS-1:0] rand_pixel();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) return FIELD_BITS'($urandom_range(0, 65535));
      if (pick < 70) return FIELD_BITS'($urandom_range(0, 511));
      if (pick < 80) return FIELD_BITS'($urandom_range(250, 260));
      if (pick < 90) return '0;
      return '1;
   endfunction

   function automatic int unsigned span_of(input logic [LINE_WIDTH_BITS-1:0] width);
      if (width < 2) return 2;
      if (width > MAX_WIDTH) return MAX_WIDTH;
      return 32'(width);
   endfunction

   // one pixel word, after an optional gap
   task automatic send_pixel(input logic [FIELD_BITS-1:0] value, input logic first);
      int gap;
      gap = (!req_burst && $urandom_range(0, 2) == 0) ? idle_span() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= '{pixel: value, frame_start: first};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // stop sending and let every predicted word come out
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [LINE_WIDTH_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // all three registers; unused data bits random; a wider line needs a new frame
   task automatic configure(input layout_type layout, input logic byte_src,
                            input logic [LINE_WIDTH_BITS-1:0] width, output bit restart);
      logic [LINE_WIDTH_BITS-1:0] data;
      int unsigned                span;
      data      = LINE_WIDTH_BITS'($urandom_range(0, (1 << LINE_WIDTH_BITS) - 1));
      data[1:0] = layout;
      write_reg(CSR_BAYER_LAYOUT, data);
      data      = LINE_WIDTH_BITS'($urandom_range(0, (1 << LINE_WIDTH_BITS) - 1));
      data[0]   = byte_src;
      write_reg(CSR_BYTE_MODE, data);
      write_reg(CSR_LINE_WIDTH, width);
      span     = span_of(width);
      restart  = span > cur_span;
      cur_span = span;
   endtask

   // raster stream with a rare stray frame start
   task automatic send_stream(input int unsigned count, input bit restart);
      for (int unsigned i = 0; i < count; i++) begin
         send_pixel(rand_pixel(), (i == 0 && restart) || $urandom_range(0, 49) == 0);
      end
   endtask

   // result side: random holds, plus one long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (stall_served != stall_requests) begin
         stall_served <= stall_requests;
         rsp_ready    <= 1'b0;
         hold_left    <= LONG_HOLD - 1;
      end else if (!rsp_burst && $urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         hold_left <= idle_span() - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // watchdog on cycles with no word moving on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus
   initial begin
      bit                         restart;
      int unsigned                count;
      int unsigned                rows;
      int                         phase;
      int                         random_sent;
      int                         pick;
      logic [LINE_WIDTH_BITS-1:0] width;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: full-scale corners, then an all-max quad
      send_pixel('1, 1'b1); send_pixel('0, 1'b0); send_pixel('0, 1'b0); send_pixel('1, 1'b0);
      repeat (4) send_pixel('1, 1'b0);
      drain_results();

      // odd width and odd height with byte clamping
      configure(LAYOUT_BGGR, 1'b1, LINE_WIDTH_BITS'(3), restart);
      send_pixel(16'd300, 1'b1); send_pixel(16'd255, 1'b0); send_pixel(16'd7, 1'b0);
      send_pixel(16'd256, 1'b0); send_pixel(16'd0, 1'b0); send_pixel(16'd9, 1'b0);
      send_pixel(16'd1, 1'b0); send_pixel(16'd2, 1'b0); send_pixel(16'd3, 1'b0);
      drain_results();

      // width below range, floor means
      configure(LAYOUT_GRBG, 1'b0, LINE_WIDTH_BITS'(0), restart);
      send_pixel(16'd1, 1'b1); send_pixel(16'd2, 1'b0); send_pixel(16'd3, 1'b0);
      send_pixel(16'd4, 1'b0);
      drain_results();

      configure(LAYOUT_GBRG, 1'b1, LINE_WIDTH_BITS'(1), restart);
      send_pixel('1, 1'b1); send_pixel(16'd65534, 1'b0); send_pixel(16'd1, 1'b0);
      send_pixel(16'd0, 1'b0);

      // random frames; a narrower line may carry on mid-frame
      phase       = 0;
      random_sent = 0;
      while (random_sent < RANDOM_PIXELS) begin
         drain_results();
         pick = $urandom_range(0, 99);
         if (pick < 70) width = LINE_WIDTH_BITS'($urandom_range(2, 16));
         else if (pick < 90) width = LINE_WIDTH_BITS'($urandom_range(17, 64));
         else width = LINE_WIDTH_BITS'($urandom_range(0, 1));
         rows      = $urandom_range(2, 5);
         req_burst = ($urandom_range(0, 3) == 0);
         if (phase == STALL_PHASE) begin
            width     = LINE_WIDTH_BITS'(16);
            rows      = 6;
            req_burst = 1'b1;
            rsp_burst <= 1'b0;
         end else begin
            rsp_burst <= ($urandom_range(0, 3) == 0);
         end
         configure(layout_type'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), width,
                   restart);
         if (phase % 7 == 3) begin
            write_reg(CSR_UNMAPPED,
                      LINE_WIDTH_BITS'($urandom_range(0, (1 << LINE_WIDTH_BITS) - 1)));
         end
         // long result hold while pixels keep coming
         if (phase == STALL_PHASE) stall_requests <= stall_requests + 1;
         count = cur_span * rows + $urandom_range(0, cur_span - 1);
         send_stream(count, restart || $urandom_range(0, 1) == 1);
         random_sent += count;
         phase++;
      end

      drain_results();
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
